// File: src/mpqs_pkg.sv
package mpqs_pkg;

   localparam int CMD_W     = 2;
   localparam int PRIO_W    = 8;
   localparam int PAYLOAD_W = 16;
   localparam int STATUS_W  = 2;
   localparam int OCC_W     = 5;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]     command;
      logic [PRIO_W-1:0]    priority_req;
      logic [PAYLOAD_W-1:0] payload;
   } mpqs_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [PRIO_W-1:0]    out_priority;
      logic [PAYLOAD_W-1:0] out_payload;
      logic [OCC_W-1:0]     occupancy;
      logic                 is_empty;
      logic                 is_full;
   } mpqs_rsp_type;

   typedef struct packed {
      logic [PRIO_W-1:0]    prio;
      logic [PAYLOAD_W-1:0] payload;
   } mpqs_slot_type;

endpackage

// File: src/max_priority_queue_scan_core.sv
// Channel  Ports                        Beat
// request  req_valid/req_stall/req_data one command: insert, remove or peek
// response rsp_valid/rsp_stall/rsp_data one result per request
//
// Insert, full, empty and unused commands go from accept to S_DONE, then to the output register.
// Peek reads the slots in order: one slot memory read per cycle during the scan.
// Remove of an entry other than the last then moves each later entry down one slot to close the gap.
// Reset clears the count and control only; slot memory needs no clearing.
// A new request is taken while a finished result waits in the output register.
module max_priority_queue_scan_core #(
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mpqs_pkg::mpqs_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mpqs_pkg::mpqs_rsp_type rsp_data
);

   import mpqs_pkg::*;

   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     issue_ff, issue_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [CNT_W-1:0]     chk_idx_ff, chk_idx_in;
   logic [CNT_W-1:0]     best_idx_ff, best_idx_in;
   logic [PRIO_W-1:0]    best_prio_ff, best_prio_in;
   logic [PAYLOAD_W-1:0] best_pay_ff, best_pay_in;
   logic                 is_remove_ff, is_remove_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   mpqs_rsp_type         rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   mpqs_slot_type        slot_mem [DEPTH];
   mpqs_slot_type        rd_data_ff;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   mpqs_slot_type        wr_data;

   logic [CNT_W-1:0]     last_idx;
   logic [CNT_W-1:0]     upd_idx;
   logic [PRIO_W-1:0]    upd_prio;
   logic [PAYLOAD_W-1:0] upd_pay;
   logic [CNT_W-1:0]     shift_dst;
   logic [CNT_W+OCC_W-1:0] occ_wide;

   assign last_idx  = count_ff - CNT_W'(1);
   assign shift_dst = chk_idx_ff - CNT_W'(1);
   assign occ_wide  = {{OCC_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      best_idx_in  = best_idx_ff;
      best_prio_in = best_prio_ff;
      best_pay_in  = best_pay_ff;
      is_remove_in = is_remove_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rd_addr      = issue_ff[AW-1:0];
      wr_en        = 1'b0;
      wr_addr      = count_ff[AW-1:0];
      wr_data      = '{prio: req_data.priority_req, payload: req_data.payload};
      upd_idx      = best_idx_ff;
      upd_prio     = best_prio_ff;
      upd_pay      = best_pay_ff;

      if (chk_vld_ff && (chk_idx_ff == '0 || rd_data_ff.prio > best_prio_ff)) begin
         upd_idx  = chk_idx_ff;
         upd_prio = rd_data_ff.prio;
         upd_pay  = rd_data_ff.payload;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               best_prio_in = '0;
               best_pay_in  = '0;
               status_in    = ST_OK;
               state_in     = S_DONE;
               unique case (req_data.command)
                  CMD_INSERT: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_REMOVE, CMD_PEEK: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        is_remove_in = (req_data.command == CMD_REMOVE);
                        issue_in     = '0;
                        state_in     = S_SCAN;
                     end
                  end
                  default: begin
                     status_in = ST_OK;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (issue_ff < count_ff) begin
               issue_in   = issue_ff + CNT_W'(1);
               chk_vld_in = 1'b1;
               chk_idx_in = issue_ff;
            end
            best_idx_in  = upd_idx;
            best_prio_in = upd_prio;
            best_pay_in  = upd_pay;
            if (chk_vld_ff && chk_idx_ff == last_idx) begin
               if (!is_remove_ff) begin
                  state_in = S_DONE;
               end else if (upd_idx == last_idx) begin
                  count_in = last_idx;
                  state_in = S_DONE;
               end else begin
                  issue_in = upd_idx + CNT_W'(1);
                  state_in = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            if (issue_ff < count_ff) begin
               issue_in   = issue_ff + CNT_W'(1);
               chk_vld_in = 1'b1;
               chk_idx_in = issue_ff;
            end
            if (chk_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = shift_dst[AW-1:0];
               wr_data = rd_data_ff;
               if (chk_idx_ff == last_idx) begin
                  count_in = last_idx;
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.status       = status_ff;
               rsp_in.out_priority = best_prio_ff;
               rsp_in.out_payload  = best_pay_ff;
               rsp_in.occupancy    = occ_wide[OCC_W-1:0];
               rsp_in.is_empty     = (count_ff == '0);
               rsp_in.is_full      = (count_ff == CNT_W'(DEPTH));
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      issue_ff     <= issue_in;
      chk_idx_ff   <= chk_idx_in;
      best_idx_ff  <= best_idx_in;
      best_prio_ff <= best_prio_in;
      best_pay_ff  <= best_pay_in;
      is_remove_ff <= is_remove_in;
      status_ff    <= status_in;
      rsp_ff       <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside completion");

   a_shift_below_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && chk_vld_ff && chk_vld_in) |-> (shift_dst < chk_idx_in))
      else $error("shift write overtakes read");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == ST_EMPTY) |->
         (rsp_ff.is_empty && rsp_ff.out_priority == '0 && rsp_ff.out_payload == '0))
      else $error("empty result carries data");
`endif

endmodule
